>>> rtl/aee_pkg.sv
package aee_pkg;

	// Animation kinds as carried on the input tuser field.
	typedef enum logic [2:0] {
		KIND_FADE   = 3'd0,
		KIND_SLIDE  = 3'd1,
		KIND_SCALE  = 3'd2,
		KIND_ROTATE = 3'd3,
		KIND_GLOW   = 3'd4,
		KIND_PULSE  = 3'd5,
		KIND_MATRIX = 3'd6,
		KIND_OTHER  = 3'd7
	} kind_t;

	// Per-item control that travels down the pipeline with the data.
	typedef struct packed {
		kind_t kind;
		logic  on;
		logic  hov;
	} ctl_t;

	// Effect constants.
	localparam int ALPHA_MAX         = 255;
	localparam int ALPHA_W           = 8;
	localparam int SLIDE_DIST        = 50;
	localparam int SLIDE_OFF_W       = 6;
	localparam int GLOW_ALPHA_SHIFT  = 7;
	localparam int GLOW_MARGIN_SHIFT = 3;
	localparam int MARGIN_W          = 4;
	localparam int SCALE_DIV         = 5;

endpackage

>>> rtl/aee_curve.sv
module aee_curve #(
	parameter int FRACTION_BITS = 16,
	parameter int SIDE_W = 62
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_vld,
	input  aee_pkg::ctl_t            in_ctl,
	input  logic [FRACTION_BITS:0]   progress,
	input  logic [SIDE_W-1:0]        in_side,
	output logic                     out_vld,
	output aee_pkg::ctl_t            out_ctl,
	output logic [FRACTION_BITS:0]   eased,
	output logic [SIDE_W-1:0]        out_side
);
	import aee_pkg::*;

	localparam int F   = FRACTION_BITS;
	localparam int PW  = F + 1;
	localparam int SQW = 2 * F + 1;
	localparam logic [PW-1:0] ONE_V  = PW'(1) << F;
	localparam logic [PW-1:0] HALF_V = PW'(1) << (F - 1);

	logic [PW-1:0]     t, u, s;
	logic              low;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [PW-1:0]     t_s1, t_s2, t_s3, t_s4;
	logic              low_s1, low_s2, low_s3, low_s4;
	logic [PW-1:0]     s_s1, s_s2;
	logic [SQW-1:0]    sq_s2, sq_s3;
	logic [SQW-1:0]    ph_s3, pl_s3;
	logic [SQW-1:0]    cube_s4;
	logic              lin_s4;
	logic [PW-1:0]     quad_s4;
	logic [PW-1:0]     eased_s5;

	logic [2*PW-1:0]   sq_full;
	logic [2*PW-1:0]   ph_full, pl_full;
	logic [SQW-1:0]    cube_sum;
	logic [PW-1:0]     q1, q2, quad_e;
	logic              qi1, qi2;
	logic [PW-1:0]     c1, c4, ease_e;
	logic              ci1, ci4;

	// Stage 1: saturate progress and pick the base that gets squared and cubed.
	always_comb begin
		t = (progress > ONE_V) ? ONE_V : progress;
		u = ONE_V - t;
		low = (t < HALF_V);
		case (in_ctl.kind) inside
			KIND_SLIDE, KIND_SCALE: s = u;
			default:                s = low ? t : u;
		endcase
	end

	// Stage 2: square of the base.
	assign sq_full = (2*PW)'(s_s1) * (2*PW)'(s_s1);

	// Stage 3: cube as two partial products on the high and low halves of the square.
	assign ph_full = (2*PW)'(sq_s2[SQW-1:F]) * (2*PW)'(s_s2);
	assign pl_full = (2*PW)'(sq_s2[F-1:0]) * (2*PW)'(s_s2);

	// Stage 4: merge the partial products and finish the quadratic curves.
	always_comb begin
		cube_sum = ph_s3 + (pl_s3 >> F);
		q1  = sq_s3[F +: PW];
		qi1 = |sq_s3[F-1:0];
		q2  = sq_s3[F-1 +: PW];
		qi2 = |sq_s3[F-2:0];
		case (ctl_s3.kind) inside
			KIND_SCALE: quad_e = ONE_V - q1 - PW'(qi1);
			default:    quad_e = low_s3 ? q2 : (ONE_V - q2 - PW'(qi2));
		endcase
	end

	// Stage 5: finish the cubic curves and select the kind's curve, or zero when the item is off.
	always_comb begin
		c1  = cube_s4[F +: PW];
		ci1 = lin_s4 | (|cube_s4[F-1:0]);
		c4  = cube_s4[F-2 +: PW];
		ci4 = lin_s4 | (|cube_s4[F-3:0]);
		case (ctl_s4.kind) inside
			KIND_FADE, KIND_GLOW, KIND_SCALE: ease_e = quad_s4;
			KIND_SLIDE:                       ease_e = ONE_V - c1 - PW'(ci1);
			KIND_PULSE: ease_e = low_s4 ? c4 : (ONE_V - c4 - PW'(ci4));
			default:                          ease_e = t_s4;
		endcase
		if (!ctl_s4.on) begin
			ease_e = '0;
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1   <= in_ctl;
			side_s1  <= in_side;
			t_s1     <= t;
			low_s1   <= low;
			s_s1     <= s;

			ctl_s2   <= ctl_s1;
			side_s2  <= side_s1;
			t_s2     <= t_s1;
			low_s2   <= low_s1;
			s_s2     <= s_s1;
			sq_s2    <= sq_full[SQW-1:0];

			ctl_s3   <= ctl_s2;
			side_s3  <= side_s2;
			t_s3     <= t_s2;
			low_s3   <= low_s2;
			sq_s3    <= sq_s2;
			ph_s3    <= ph_full[SQW-1:0];
			pl_s3    <= pl_full[SQW-1:0];

			ctl_s4   <= ctl_s3;
			side_s4  <= side_s3;
			t_s4     <= t_s3;
			low_s4   <= low_s3;
			cube_s4  <= cube_sum;
			lin_s4   <= |pl_s3[F-1:0];
			quad_s4  <= quad_e;

			ctl_s5   <= ctl_s4;
			side_s5  <= side_s4;
			eased_s5 <= ease_e;
		end
	end

	assign out_vld  = vld_s5;
	assign out_ctl  = ctl_s5;
	assign eased    = eased_s5;
	assign out_side = side_s5;

endmodule

>>> rtl/aee_div5.sv
module aee_div5 #(
	parameter int N = 15
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [N-1:0] n,
	output logic [N-1:0] q
);
	import aee_pkg::*;

	// Reciprocal estimate is low by at most one; the remainder fixes it.
	localparam int K  = N + 3;
	localparam int MW = N + 1;
	localparam longint unsigned RECIP = (64'd1 << K) / 64'(SCALE_DIV);
	localparam logic [MW-1:0] RECIP_V = MW'(RECIP);

	logic [N+MW-1:0] prod;
	logic [N-3:0]    q0_s1;
	logic [N-1:0]    n_s1;
	logic [N-1:0]    q5, r;
	logic [1:0]      inc;
	logic [N-1:0]    q_s2;

	// Stage 1: estimate of the quotient.
	assign prod = (N+MW)'(n) * (N+MW)'(RECIP_V);

	// Stage 2: remainder check rounds the estimate up to the ceiling.
	always_comb begin
		q5 = {q0_s1, 2'b00} + N'(q0_s1);
		r  = n_s1 - q5;
		if (r == '0) begin
			inc = 2'd0;
		end else if (r <= N'(SCALE_DIV)) begin
			inc = 2'd1;
		end else begin
			inc = 2'd2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q0_s1 <= prod[N+MW-1:K];
			n_s1  <= n;
			q_s2  <= N'(q0_s1) + N'(inc);
		end
	end

	assign q = q_s2;

endmodule

>>> rtl/aee_effect.sv
module aee_effect #(
	parameter int FRACTION_BITS = 16,
	parameter int COORD_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_vld,
	input  aee_pkg::ctl_t                     in_ctl,
	input  logic [FRACTION_BITS:0]            in_eased,
	input  logic [COORD_BITS-1:0]             pos_x,
	input  logic [COORD_BITS-1:0]             pos_y,
	input  logic [COORD_BITS-2:0]             box_width,
	input  logic [COORD_BITS-2:0]             box_height,
	output logic                              out_vld,
	output logic [FRACTION_BITS:0]            eased,
	output logic                              alpha_write,
	output logic [aee_pkg::ALPHA_W-1:0]       alpha_out,
	output logic [COORD_BITS:0]               new_x,
	output logic [COORD_BITS:0]               new_y,
	output logic [COORD_BITS-2:0]             new_width,
	output logic [COORD_BITS-2:0]             new_height,
	output logic                              glow_draw,
	output logic [aee_pkg::ALPHA_W-1:0]       glow_alpha,
	output logic [aee_pkg::MARGIN_W-1:0]      glow_margin
);
	import aee_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int PW = F + 1;
	localparam int C  = COORD_BITS;
	localparam int CW = C - 1;
	localparam int OW = SLIDE_OFF_W;
	localparam logic [PW-1:0] ONE_V = PW'(1) << F;

	logic [PW+ALPHA_W-1:0] a_prod;
	logic [PW-1:0]         ne;
	logic [PW+OW-1:0]      o_prod;
	logic [CW+PW-1:0]      mw_prod, mh_prod;

	logic              vld_s6, vld_s7, vld_s8, vld_s9;
	ctl_t              ctl_s6, ctl_s7, ctl_s8;
	logic [PW-1:0]     e_s6, e_s7, e_s8;
	logic [ALPHA_W-1:0] a_s6, a_s7, a_s8;
	logic [OW-1:0]     off_s6, off_s7, off_s8;
	logic [C-1:0]      x_s6, x_s7, x_s8;
	logic [C-1:0]      y_s6, y_s7, y_s8;
	logic [CW-1:0]     w_s6, w_s7, w_s8;
	logic [CW-1:0]     h_s6, h_s7, h_s8;
	logic [CW-1:0]     mw_s6, mh_s6;
	logic [CW-1:0]     cw_dn, ch_dn;

	logic [CW-1:0]     nw, nh;
	logic [C:0]        x_ext, y_ext, cx, cy;
	logic [C:0]        nx, ny;
	logic              is_on;

	logic [PW-1:0]     eased_s9;
	logic              aw_s9, gd_s9;
	logic [ALPHA_W-1:0] ao_s9, ga_s9;
	logic [C:0]        nx_s9, ny_s9;
	logic [CW-1:0]     nw_s9, nh_s9;
	logic [MARGIN_W-1:0] gm_s9;

	// Stage 6: fade alpha, slide offset and the scaled part of width and height.
	always_comb begin
		a_prod  = (PW+ALPHA_W)'(in_eased) * (PW+ALPHA_W)'(ALPHA_MAX);
		ne      = ONE_V - in_eased;
		o_prod  = (PW+OW)'(ne) * (PW+OW)'(SLIDE_DIST);
		mw_prod = (CW+PW)'(box_width) * (CW+PW)'(in_eased);
		mh_prod = (CW+PW)'(box_height) * (CW+PW)'(in_eased);
	end

	// Stages 7 and 8: the shrink of each side is ceil((w - w*eased) / 5).
	aee_div5 #(.N(CW)) u_div_w (
		.clk (clk),
		.adv (adv),
		.n   (w_s6 - mw_s6),
		.q   (cw_dn)
	);

	aee_div5 #(.N(CW)) u_div_h (
		.clk (clk),
		.adv (adv),
		.n   (h_s6 - mh_s6),
		.q   (ch_dn)
	);

	// Stage 9: apply the kind's effect to the rectangle and the alpha fields.
	always_comb begin
		is_on = ctl_s8.on;
		nw    = w_s8 - cw_dn;
		nh    = h_s8 - ch_dn;
		x_ext = {x_s8[C-1], x_s8};
		y_ext = {y_s8[C-1], y_s8};
		cx    = x_ext + (C+1)'(w_s8[CW-1:1]);
		cy    = y_ext + (C+1)'(h_s8[CW-1:1]);
		nx    = x_ext;
		ny    = y_ext;
		if (is_on && (ctl_s8.kind == KIND_SLIDE)) begin
			nx = x_ext + (C+1)'(off_s8);
		end else if (is_on && (ctl_s8.kind == KIND_SCALE)) begin
			nx = cx - (C+1)'(nw[CW-1:1]);
			ny = cy - (C+1)'(nh[CW-1:1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= in_vld;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s6 <= in_ctl;
			e_s6   <= in_eased;
			a_s6   <= a_prod[F +: ALPHA_W];
			off_s6 <= o_prod[F +: OW];
			x_s6   <= pos_x;
			y_s6   <= pos_y;
			w_s6   <= box_width;
			h_s6   <= box_height;
			mw_s6  <= mw_prod[F +: CW];
			mh_s6  <= mh_prod[F +: CW];

			ctl_s7 <= ctl_s6;
			e_s7   <= e_s6;
			a_s7   <= a_s6;
			off_s7 <= off_s6;
			x_s7   <= x_s6;
			y_s7   <= y_s6;
			w_s7   <= w_s6;
			h_s7   <= h_s6;

			ctl_s8 <= ctl_s7;
			e_s8   <= e_s7;
			a_s8   <= a_s7;
			off_s8 <= off_s7;
			x_s8   <= x_s7;
			y_s8   <= y_s7;
			w_s8   <= w_s7;
			h_s8   <= h_s7;

			eased_s9 <= e_s8;
			aw_s9    <= is_on && (ctl_s8.kind == KIND_FADE);
			ao_s9    <= (is_on && (ctl_s8.kind == KIND_FADE)) ? a_s8 : '0;
			nx_s9    <= nx;
			ny_s9    <= ny;
			nw_s9    <= (is_on && (ctl_s8.kind == KIND_SCALE)) ? nw : w_s8;
			nh_s9    <= (is_on && (ctl_s8.kind == KIND_SCALE)) ? nh : h_s8;
			gd_s9    <= is_on && ctl_s8.hov && (ctl_s8.kind == KIND_GLOW);
			if (is_on && ctl_s8.hov && (ctl_s8.kind == KIND_GLOW)) begin
				ga_s9 <= e_s8[F-GLOW_ALPHA_SHIFT +: ALPHA_W];
				gm_s9 <= e_s8[F-GLOW_MARGIN_SHIFT +: MARGIN_W];
			end else begin
				ga_s9 <= '0;
				gm_s9 <= '0;
			end
		end
	end

	assign out_vld     = vld_s9;
	assign eased       = eased_s9;
	assign alpha_write = aw_s9;
	assign alpha_out   = ao_s9;
	assign new_x       = nx_s9;
	assign new_y       = ny_s9;
	assign new_width   = nw_s9;
	assign new_height  = nh_s9;
	assign glow_draw   = gd_s9;
	assign glow_alpha  = ga_s9;
	assign glow_margin = gm_s9;

endmodule

>>> rtl/animation_easing_effect_eval_unit.sv
// Throughput: one item per cycle unless m_tready stalls; nine register stages, the widest being the
// squaring and cubing multipliers of the curve and the width/height products.
// A stall on m_tready freezes all stages at once, so nothing is lost or repeated.
// Reset (arst_n low) clears only the stage valid bits; the output goes empty.
module animation_easing_effect_eval_unit #(
	parameter int FRACTION_BITS = 16,
	parameter int COORD_BITS = 16,
	localparam int IN_BITS = FRACTION_BITS + 4 * COORD_BITS + 1,
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = FRACTION_BITS + 4 * COORD_BITS + 23,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// anim_on, progress, hovered, pos_x, pos_y, box_width, box_height, zero fill
	input  logic [IN_W-1:0]               s_tdata,
	// kind
	input  logic [$bits(aee_pkg::kind_t)-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// eased, alpha_write, alpha_out, new_x, new_y, new_width, new_height,
	// glow_draw, glow_alpha, glow_margin, zero fill
	output logic [OUT_W-1:0]              m_tdata
);
	import aee_pkg::*;

	localparam int F  = FRACTION_BITS;
	localparam int C  = COORD_BITS;
	localparam int PW = F + 1;
	localparam int CW = C - 1;
	localparam int SIDE_W = 2 * C + 2 * CW;

	// Input field offsets.
	localparam int ON_LSB   = 0;
	localparam int PROG_LSB = ON_LSB + 1;
	localparam int HOV_LSB  = PROG_LSB + PW;
	localparam int X_LSB    = HOV_LSB + 1;
	localparam int Y_LSB    = X_LSB + C;
	localparam int W_LSB    = Y_LSB + C;
	localparam int H_LSB    = W_LSB + CW;

	// Output field offsets.
	localparam int E_LSB  = 0;
	localparam int AW_LSB = E_LSB + PW;
	localparam int AO_LSB = AW_LSB + 1;
	localparam int NX_LSB = AO_LSB + ALPHA_W;
	localparam int NY_LSB = NX_LSB + C + 1;
	localparam int NW_LSB = NY_LSB + C + 1;
	localparam int NH_LSB = NW_LSB + CW;
	localparam int GD_LSB = NH_LSB + CW;
	localparam int GA_LSB = GD_LSB + 1;
	localparam int GM_LSB = GA_LSB + ALPHA_W;

	logic              adv;
	ctl_t              in_ctl;
	logic [SIDE_W-1:0] in_side;

	logic              crv_vld;
	ctl_t              crv_ctl;
	logic [PW-1:0]     crv_eased;
	logic [SIDE_W-1:0] crv_side;

	logic              res_vld;
	logic [PW-1:0]     res_eased;
	logic              res_aw;
	logic [ALPHA_W-1:0] res_ao;
	logic [C:0]        res_nx, res_ny;
	logic [CW-1:0]     res_nw, res_nh;
	logic              res_gd;
	logic [ALPHA_W-1:0] res_ga;
	logic [MARGIN_W-1:0] res_gm;

	// The whole pipeline moves when the output register is empty or being drained.
	assign adv      = !res_vld || m_tready;
	assign s_tready = adv;

	// Unpack the input item.
	always_comb begin
		in_ctl.kind = kind_t'(s_tuser);
		in_ctl.on   = s_tdata[ON_LSB];
		in_ctl.hov  = s_tdata[HOV_LSB];
		in_side     = {s_tdata[H_LSB +: CW], s_tdata[W_LSB +: CW],
			s_tdata[Y_LSB +: C], s_tdata[X_LSB +: C]};
	end

	aee_curve #(
		.FRACTION_BITS (F),
		.SIDE_W        (SIDE_W)
	) u_curve (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_vld   (s_tvalid && s_tready),
		.in_ctl   (in_ctl),
		.progress (s_tdata[PROG_LSB +: PW]),
		.in_side  (in_side),
		.out_vld  (crv_vld),
		.out_ctl  (crv_ctl),
		.eased    (crv_eased),
		.out_side (crv_side)
	);

	aee_effect #(
		.FRACTION_BITS (F),
		.COORD_BITS    (C)
	) u_effect (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.in_vld      (crv_vld),
		.in_ctl      (crv_ctl),
		.in_eased    (crv_eased),
		.pos_x       (crv_side[0 +: C]),
		.pos_y       (crv_side[C +: C]),
		.box_width   (crv_side[2*C +: CW]),
		.box_height  (crv_side[2*C+CW +: CW]),
		.out_vld     (res_vld),
		.eased       (res_eased),
		.alpha_write (res_aw),
		.alpha_out   (res_ao),
		.new_x       (res_nx),
		.new_y       (res_ny),
		.new_width   (res_nw),
		.new_height  (res_nh),
		.glow_draw   (res_gd),
		.glow_alpha  (res_ga),
		.glow_margin (res_gm)
	);

	// Pack the result item.
	always_comb begin
		m_tdata = '0;
		m_tdata[E_LSB +: PW]        = res_eased;
		m_tdata[AW_LSB]             = res_aw;
		m_tdata[AO_LSB +: ALPHA_W]  = res_ao;
		m_tdata[NX_LSB +: C+1]      = res_nx;
		m_tdata[NY_LSB +: C+1]      = res_ny;
		m_tdata[NW_LSB +: CW]       = res_nw;
		m_tdata[NH_LSB +: CW]       = res_nh;
		m_tdata[GD_LSB]             = res_gd;
		m_tdata[GA_LSB +: ALPHA_W]  = res_ga;
		m_tdata[GM_LSB +: MARGIN_W] = res_gm;
	end

	assign m_tvalid = res_vld;

	// The output stays empty in the cycle reset is released.
	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result valid right after reset");

	// Fade and glow never act on the same item.
	a_fade_glow_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[AW_LSB] && m_tdata[GD_LSB]))
		else $error("fade and glow both active");

	// Glow fields stay within their scale, and the glow margin is zero without a glow.
	a_glow_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[GA_LSB +: ALPHA_W] <= ALPHA_W'(128))
			&& (m_tdata[GM_LSB +: MARGIN_W] <= MARGIN_W'(8))
			&& (m_tdata[GD_LSB] || (m_tdata[GM_LSB +: MARGIN_W] == '0))))
		else $error("glow fields out of range");

	// Alpha is only written for a fade, and eased never exceeds one.
	a_alpha_eased: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[AW_LSB] || (m_tdata[AO_LSB +: ALPHA_W] == '0))
			&& (m_tdata[E_LSB +: PW] <= (PW'(1) << F))))
		else $error("alpha or eased out of range");

endmodule
